// ===== src/ipid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_pkg
// shared types, constants, microcode table and helpers of the speed controller
// ----------------------------------------------------------------------------
package ipid_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int STEP_W  = 4;
    localparam int CFG_W   = 32;
    localparam int PROD_W  = 50;   // signed 17 x signed 33
    localparam int SUM_W   = 51;   // sum of three products
    localparam int ACC_W   = 52;   // accumulator plus increment before clamp
    localparam int REF_SHIFT   = 16;
    localparam int RECIP_SHIFT = 30;
    // ceil(2^30 / 100): floor(x / 100) = (x * PCT_RECIP) >> 30 for x below 2^23
    localparam logic [32:0] PCT_RECIP = 33'd10737419;
    localparam logic signed [15:0] PCT_MAX = 16'sd100;

    localparam logic        CLOSED_LOOP_RST = 1'b1;
    localparam logic [15:0] DUTY_LIMIT_RST  = 16'd10000;
    localparam logic [31:0] REF_GAIN_RST    = 32'd65536;
    localparam logic [14:0] SPEED_LIMIT_RST = 15'd32767;

    typedef enum logic [2:0] {
        REG_CLOSED_LOOP = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_DEAD_BAND   = 3'd4,
        REG_DUTY_LIMIT  = 3'd5,
        REG_REF_GAIN    = 3'd6,
        REG_SPEED_LIMIT = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MA_SPEED,
        MA_GAIN_P,
        MA_GAIN_I,
        MA_GAIN_D,
        MA_LIMIT,
        MA_PCT
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_REF_GAIN,
        MB_ERR,
        MB_DELTA,
        MB_DDELTA,
        MB_RECIP,
        MB_PROD
    } mul_b_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,
        OP_DELTA,
        OP_DDELTA,
        OP_SUM_ADD,
        OP_ACC,
        OP_CLOSE_EMIT,
        OP_OPEN_EMIT
    } op_t;

    typedef struct packed {
        logic              mul_en;
        mul_a_t            mul_a;
        mul_b_t            mul_b;
        op_t               op;
        logic              br_open;   // jump to target when in open-loop mode
        logic [STEP_W-1:0] target;
        logic              wait_out;  // hold here until the output register is free
        logic              last;
    } uword_t;

    typedef struct packed {
        logic   busy;
        logic   go;      // current word executes this cycle
        uword_t uw;
    } seq_ctrl_t;

    localparam logic [STEP_W-1:0] STEP_OPEN = STEP_W'(8);

    function automatic uword_t uword(input logic m, input mul_a_t a, input mul_b_t b,
                                     input op_t o, input logic br, input logic w,
                                     input logic l);
        uword_t r;
        r.mul_en   = m;
        r.mul_a    = a;
        r.mul_b    = b;
        r.op       = o;
        r.br_open  = br;
        r.target   = STEP_OPEN;
        r.wait_out = w;
        r.last     = l;
        return r;
    endfunction

    // control program: closed loop runs steps 0..7, open loop 0 then 8..10
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t r;
        r = uword(1'b0, MA_SPEED, MB_REF_GAIN, OP_NONE, 1'b0, 1'b0, 1'b1);
        unique case (step)
            4'd0:  r = uword(1'b1, MA_SPEED,  MB_REF_GAIN, OP_NONE,       1'b1, 1'b0, 1'b0);
            4'd1:  r = uword(1'b0, MA_SPEED,  MB_REF_GAIN, OP_ERR,        1'b0, 1'b0, 1'b0);
            4'd2:  r = uword(1'b1, MA_GAIN_I, MB_ERR,      OP_DELTA,      1'b0, 1'b0, 1'b0);
            4'd3:  r = uword(1'b1, MA_GAIN_P, MB_DELTA,    OP_DDELTA,     1'b0, 1'b0, 1'b0);
            4'd4:  r = uword(1'b1, MA_GAIN_D, MB_DDELTA,   OP_SUM_ADD,    1'b0, 1'b0, 1'b0);
            4'd5:  r = uword(1'b0, MA_SPEED,  MB_REF_GAIN, OP_SUM_ADD,    1'b0, 1'b0, 1'b0);
            4'd6:  r = uword(1'b0, MA_SPEED,  MB_REF_GAIN, OP_ACC,        1'b0, 1'b0, 1'b0);
            4'd7:  r = uword(1'b0, MA_SPEED,  MB_REF_GAIN, OP_CLOSE_EMIT, 1'b0, 1'b1, 1'b1);
            4'd8:  r = uword(1'b1, MA_PCT,    MB_RECIP,    OP_NONE,       1'b0, 1'b0, 1'b0);
            4'd9:  r = uword(1'b1, MA_LIMIT,  MB_PROD,     OP_NONE,       1'b0, 1'b0, 1'b0);
            4'd10: r = uword(1'b0, MA_SPEED,  MB_REF_GAIN, OP_OPEN_EMIT,  1'b0, 1'b1, 1'b1);
            default: r = uword(1'b0, MA_SPEED, MB_REF_GAIN, OP_NONE, 1'b0, 1'b0, 1'b1);
        endcase
        return r;
    endfunction

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/ipid_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_sequencer
// step counter and microcode table that drive the controller datapath
// ----------------------------------------------------------------------------
module ipid_sequencer
    import ipid_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic closed_loop,
    input  wire logic out_free,
    output seq_ctrl_t ctrl
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;
    logic              go;

    always_comb
    begin
        uw = ucode(step_reg);
        go = busy_reg && (!uw.wait_out || out_free);
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (go)
        begin
            priority if (uw.last)
                busy_next = 1'b0;
            else if (uw.br_open && !closed_loop)
                step_next = uw.target;
            else
                step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctrl.busy = busy_reg;
    assign ctrl.go   = go;
    assign ctrl.uw   = uw;

endmodule
`default_nettype wire

// ===== src/incremental_pid_motor_speed_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pid_motor_speed_control
// incremental pid speed loop with deadband, or open-loop percent drive
// ----------------------------------------------------------------------------
// One input word is one control period. A microcoded sequencer runs a short
// program over a single shared 17 x 33 signed multiplier with a registered
// product: closed loop takes eight steps (reference scaling, error terms,
// three gain products, accumulator update, clamp and output), open loop four.
// A new word is taken only once the program of the last one has finished;
// one result may wait in the output register while the next word is being
// worked on, and the final step holds until that register is free.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module incremental_pid_motor_speed_control
    import ipid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input words
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // speed_set[15:0], encoder_count[31:16]
    input  wire logic              s_tuser,   // link_up
    // result words
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // duty[15:0], drive_value[32:16], zero pad
    output logic                   m_tuser,   // direction
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam logic [SUM_W-1:0] FRAC_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic [PROD_W-1:0] REF_BIAS = PROD_W'((64'd1 << REF_SHIFT) - 64'd1);

    // configuration registers
    logic        closed_loop_reg;
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [11:0] dead_band_reg;
    logic [15:0] duty_limit_reg;
    logic [31:0] ref_gain_reg;
    logic [14:0] speed_limit_reg;

    // datapath
    logic signed [15:0]       speed_reg, speed_next;
    logic signed [15:0]       enc_reg;
    logic                     link_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [31:0]       err_reg, err_next;
    logic signed [31:0]       delta_reg, delta_next;
    logic signed [31:0]       ddelta_reg, ddelta_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [ACC_W-1:0]  acc_wide_reg, acc_wide_next;
    logic signed [31:0]       last_error_reg, last_error_next;
    logic signed [31:0]       last_delta_reg, last_delta_next;
    logic signed [16:0]       acc_reg, acc_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        duty_reg, duty_next;
    logic               dir_reg, dir_next;
    logic signed [16:0] drive_reg, drive_next;

    seq_ctrl_t ctrl;
    logic      accept;
    logic      out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    ipid_sequencer u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .closed_loop (closed_loop_reg),
        .out_free    (out_free),
        .ctrl        (ctrl)
    );

    assign s_tready = !ctrl.busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_loop_reg <= CLOSED_LOOP_RST;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            dead_band_reg   <= '0;
            duty_limit_reg  <= DUTY_LIMIT_RST;
            ref_gain_reg    <= REF_GAIN_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CLOSED_LOOP: closed_loop_reg <= cfg_data[0];
                REG_GAIN_P:      gain_p_reg      <= cfg_data[15:0];
                REG_GAIN_I:      gain_i_reg      <= cfg_data[15:0];
                REG_GAIN_D:      gain_d_reg      <= cfg_data[15:0];
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data[11:0];
                REG_DUTY_LIMIT:  duty_limit_reg  <= cfg_data[15:0];
                REG_REF_GAIN:    ref_gain_reg    <= cfg_data[31:0];
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[14:0];
                default:         closed_loop_reg <= closed_loop_reg;
            endcase
        end
    end

    // input clamp, by mode
    logic signed [15:0] in_speed;
    logic signed [15:0] clamp_hi;
    always_comb
    begin
        in_speed = $signed(s_tdata[15:0]);
        clamp_hi = closed_loop_reg ? $signed({1'b0, speed_limit_reg}) : PCT_MAX;
        priority if (in_speed > clamp_hi)
            speed_next = clamp_hi;
        else if (in_speed < -clamp_hi)
            speed_next = -clamp_hi;
        else
            speed_next = in_speed;
    end

    // shared multiplier
    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic        [6:0]  pct_mag;
    logic signed [16:0] lim_s;

    assign pct_mag = speed_reg[15] ? 7'(-speed_reg) : speed_reg[6:0];
    assign lim_s   = $signed({1'b0, duty_limit_reg});

    always_comb
    begin
        unique case (ctrl.uw.mul_a)
            MA_SPEED:  mul_a = 17'(speed_reg);
            MA_GAIN_P: mul_a = $signed({1'b0, gain_p_reg});
            MA_GAIN_I: mul_a = $signed({1'b0, gain_i_reg});
            MA_GAIN_D: mul_a = $signed({1'b0, gain_d_reg});
            MA_LIMIT:  mul_a = lim_s;
            MA_PCT:    mul_a = $signed({10'd0, pct_mag});
            default:   mul_a = '0;
        endcase
        unique case (ctrl.uw.mul_b)
            MB_REF_GAIN: mul_b = $signed({1'b0, ref_gain_reg});
            MB_ERR:      mul_b = 33'(err_reg);
            MB_DELTA:    mul_b = 33'(delta_reg);
            MB_DDELTA:   mul_b = 33'(ddelta_reg);
            MB_RECIP:    mul_b = $signed(PCT_RECIP);
            MB_PROD:     mul_b = $signed({1'b0, prod_reg[31:0]});
            default:     mul_b = '0;
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // arithmetic of the program steps
    logic signed [PROD_W-1:0] ref_full;
    logic signed [33:0]       ref_diff;
    logic signed [SUM_W-1:0]  inc;
    logic        [32:0]       err_mag;
    logic signed [16:0]       open_mag;
    logic        [16:0]       drive_mag;

    always_comb
    begin
        // reference count, truncated toward zero
        ref_full = prod_reg[PROD_W-1] ? ((prod_reg + $signed(REF_BIAS)) >>> REF_SHIFT)
                                      : (prod_reg >>> REF_SHIFT);
        ref_diff = 34'($signed(ref_full[31:0])) - 34'(enc_reg);
        inc      = sum_reg[SUM_W-1] ? ((sum_reg + $signed(FRAC_BIAS)) >>> GAIN_FRAC_BITS)
                                    : (sum_reg >>> GAIN_FRAC_BITS);
        err_mag  = err_reg[31] ? 33'(-33'(err_reg)) : 33'(err_reg);
        open_mag = $signed({1'b0, prod_reg[RECIP_SHIFT+15:RECIP_SHIFT]});

        err_next        = err_reg;
        delta_next      = delta_reg;
        ddelta_next     = ddelta_reg;
        sum_next        = sum_reg;
        acc_wide_next   = acc_wide_reg;
        last_error_next = last_error_reg;
        last_delta_next = last_delta_reg;
        acc_next        = acc_reg;
        drive_next      = drive_reg;

        if (ctrl.go)
        begin
            unique case (ctrl.uw.op)
                OP_NONE: ;
                OP_ERR:
                    err_next = sat32(ref_diff);
                OP_DELTA:
                    delta_next = sat32(34'(err_reg) - 34'(last_error_reg));
                OP_DDELTA:
                begin
                    ddelta_next = sat32(34'(delta_reg) - 34'(last_delta_reg));
                    sum_next    = SUM_W'(prod_reg);
                end
                OP_SUM_ADD:
                    sum_next = sum_reg + SUM_W'(prod_reg);
                OP_ACC:
                begin
                    // deadband: only add the increment when the error reaches the deadband
                    if (err_mag >= {21'd0, dead_band_reg})
                        acc_wide_next = ACC_W'(acc_reg) + ACC_W'(inc);
                    else
                        acc_wide_next = ACC_W'(acc_reg);
                    last_error_next = err_reg;
                    last_delta_next = delta_reg;
                end
                OP_CLOSE_EMIT:
                begin
                    priority if (acc_wide_reg >= ACC_W'(lim_s))
                        acc_next = lim_s;
                    else if (acc_wide_reg <= ACC_W'(-lim_s))
                        acc_next = -lim_s;
                    else
                        acc_next = acc_wide_reg[16:0];
                    drive_next = acc_next;
                end
                OP_OPEN_EMIT:
                    drive_next = speed_reg[15] ? -open_mag : open_mag;
                default: ;
            endcase
        end

        // result word
        drive_mag = drive_next[16] ? 17'(-drive_next) : 17'(drive_next);
        if (!link_reg)
        begin
            duty_next = '0;
            dir_next  = 1'b1;
        end
        else
        begin
            duty_next = (drive_mag > {1'b0, duty_limit_reg}) ? duty_limit_reg
                                                             : drive_mag[15:0];
            dir_next  = !drive_next[16];
        end

        m_valid_next = m_valid_reg && !m_tready;
        if (ctrl.go && (ctrl.uw.op == OP_CLOSE_EMIT || ctrl.uw.op == OP_OPEN_EMIT))
            m_valid_next = 1'b1;
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            last_error_reg <= '0;
            last_delta_reg <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            m_valid_reg    <= m_valid_next;
            last_error_reg <= last_error_next;
            last_delta_reg <= last_delta_next;
            acc_reg        <= acc_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed_reg <= speed_next;
            enc_reg   <= $signed(s_tdata[31:16]);
            link_reg  <= s_tuser;
        end
        if (ctrl.go && ctrl.uw.mul_en)
            prod_reg <= prod_next;
        err_reg      <= err_next;
        delta_reg    <= delta_next;
        ddelta_reg   <= ddelta_next;
        sum_reg      <= sum_next;
        acc_wide_reg <= acc_wide_next;
        if (ctrl.go && (ctrl.uw.op == OP_CLOSE_EMIT || ctrl.uw.op == OP_OPEN_EMIT))
        begin
            drive_reg <= drive_next;
            duty_reg  <= duty_next;
            dir_reg   <= dir_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, drive_reg, duty_reg};
    assign m_tuser  = dir_reg;

`ifndef SYNTHESIS
    // an accepted word keeps the sequencer busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctrl.busy)
        else $error("sequencer not busy after accept");

    // accumulator lands inside the duty limit after each clamp
    a_acc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.go && ctrl.uw.op == OP_CLOSE_EMIT)
            |=> (acc_reg <= lim_s && acc_reg >= -lim_s))
        else $error("accumulator outside duty limit");

    // a result is never loaded over one that was not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |-> !(ctrl.go && ctrl.uw.wait_out))
        else $error("result overwritten");

    // a waiting duty never exceeds the limit
    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (duty_reg <= duty_limit_reg))
        else $error("duty above limit");
`endif

endmodule
`default_nettype wire

// ===== tb/incremental_pid_motor_speed_control_tb.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_motor_speed_control_tb
// self-checking bench for the incremental pid speed controller
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the control registers and of the
// pid state. It computes the duty, direction and drive of every accepted
// control period and compares them with the result words in order.
// A directed part covers the field extremes, the deadband, error
// saturation, open-loop scaling, link down and a shrinking duty limit.
// Random phases with fresh register settings follow. Encoder counts mostly
// track the scaled setpoint so that the loop sees realistic small errors.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module incremental_pid_motor_speed_control_tb;
    import ipid_pkg::*;

    localparam int GAIN_FRAC     = GAIN_FRAC_BITS_DEF;
    localparam int RUN_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 150;

    typedef struct packed {
        logic [15:0] duty;
        logic        fwd;
        logic [16:0] drive;
    } drive_result_t;

    class speed_loop_scoreboard;
        bit            closed_loop;
        bit [15:0]     gain_p;
        bit [15:0]     gain_i;
        bit [15:0]     gain_d;
        bit [11:0]     dead_band;
        bit [15:0]     duty_limit;
        bit [31:0]     ref_gain;
        bit [14:0]     speed_limit;
        longint        last_err;
        longint        last_delta;
        longint        accum;
        drive_result_t pending_q[$];
        int            errors;

        function new();
            closed_loop = CLOSED_LOOP_RST;
            gain_p      = '0;
            gain_i      = '0;
            gain_d      = '0;
            dead_band   = '0;
            duty_limit  = DUTY_LIMIT_RST;
            ref_gain    = REF_GAIN_RST;
            speed_limit = SPEED_LIMIT_RST;
            last_err    = 0;
            last_delta  = 0;
            accum       = 0;
            errors      = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_CLOSED_LOOP: closed_loop = value[0];
                REG_GAIN_P:      gain_p      = value[15:0];
                REG_GAIN_I:      gain_i      = value[15:0];
                REG_GAIN_D:      gain_d      = value[15:0];
                REG_DEAD_BAND:   dead_band   = value[11:0];
                REG_DUTY_LIMIT:  duty_limit  = value[15:0];
                REG_REF_GAIN:    ref_gain    = value;
                REG_SPEED_LIMIT: speed_limit = value[14:0];
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // division by a power of two, rounding toward zero
        function longint shift_trunc(longint v, int s);
            if (v >= 0)
                return v >>> s;
            return -((-v) >>> s);
        endfunction

        function void note_input(logic [31:0] data, logic link);
            longint        spd;
            longint        enc;
            longint        lim;
            longint        ref_cnt;
            longint        err;
            longint        dlt;
            longint        dd;
            longint        mag;
            longint        drv;
            drive_result_t want;
            spd = longint'($signed(data[15:0]));
            enc = longint'($signed(data[31:16]));
            lim = longint'(duty_limit);
            if (closed_loop) begin
                if (spd > longint'(speed_limit))
                    spd = longint'(speed_limit);
                else if (spd < -longint'(speed_limit))
                    spd = -longint'(speed_limit);
                ref_cnt    = shift_trunc(spd * longint'(ref_gain), REF_SHIFT);
                err        = sat32(ref_cnt - enc);
                dlt        = sat32(err - last_err);
                dd         = sat32(dlt - last_delta);
                last_err   = err;
                last_delta = dlt;
                mag = (err < 0) ? -err : err;
                if (mag >= longint'(dead_band))
                    accum += shift_trunc(longint'(gain_p) * dlt + longint'(gain_i) * err
                                         + longint'(gain_d) * dd, GAIN_FRAC);
                // a lowered duty limit bites here even inside the deadband
                if (accum > lim)
                    accum = lim;
                else if (accum < -lim)
                    accum = -lim;
                drv = accum;
            end
            else begin
                if (spd > 100)
                    spd = 100;
                else if (spd < -100)
                    spd = -100;
                mag = lim * ((spd < 0) ? -spd : spd) / 100;
                drv = (spd < 0) ? -mag : mag;
            end
            mag = (drv < 0) ? -drv : drv;
            if (mag > lim)
                mag = lim;
            want.drive = drv[16:0];
            want.fwd   = (drv >= 0) || !link;
            want.duty  = link ? mag[15:0] : 16'd0;
            pending_q.push_back(want);
        endfunction

        task report(input string what);
            errors++;
            $display("check failed: %s", what);
        endtask

        task check_result(input logic [39:0] data, input logic fwd);
            drive_result_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("result word %h with nothing expected", data));
                return;
            end
            want = pending_q.pop_front();
            if (data[15:0] !== want.duty)
                report($sformatf("duty %0d, expected %0d", data[15:0], want.duty));
            if (fwd !== want.fwd)
                report($sformatf("direction %b, expected %b", fwd, want.fwd));
            if (data[32:16] !== want.drive)
                report($sformatf("drive %h, expected %h", data[32:16], want.drive));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // speed_set[15:0], encoder_count[31:16]
    logic        s_tuser   = 1'b0; // link_up
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // duty[15:0], drive_value[32:16], zero pad
    logic        m_tuser;          // direction
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    bit idle_on     = 1'b1;
    int stall_left  = 0;
    int cycle_count = 0;

    speed_loop_scoreboard sb = new();

    incremental_pid_motor_speed_control #(
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("incremental_pid_motor_speed_control_tb: errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end
        else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end
        else begin
            stall_left = gap_len();
            m_tready   <= (stall_left == 0);
            if (stall_left != 0)
                stall_left = stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tdata, s_tuser);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high after the handshake so back-to-back words need no toggle
    task automatic send_word(input int spd, input int enc, input bit link);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {enc[15:0], spd[15:0]};
        s_tuser  <= link;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // one edge first so that a word taken at this edge is already noted
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mode 0 puts every register at its top, mode 1 at zero
    function automatic logic [31:0] pick_setting(input cfg_idx_t idx, input int mode);
        logic [31:0] top;
        logic [31:0] lo;
        logic [31:0] hi;
        int          r;
        case (idx)
            REG_CLOSED_LOOP: begin
                top = 32'd1; lo = 32'd1; hi = 32'd1;
            end
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
                top = 32'hFFFF; lo = 32'd0; hi = 32'd600;
            end
            REG_DEAD_BAND: begin
                top = 32'hFFF; lo = 32'd0; hi = 32'd20;
            end
            REG_DUTY_LIMIT: begin
                top = 32'hFFFF; lo = 32'd100; hi = 32'd20000;
            end
            REG_REF_GAIN: begin
                top = 32'hFFFF_FFFF; lo = 32'd16384; hi = 32'd262144;
            end
            default: begin
                top = 32'h7FFF; lo = 32'd100; hi = 32'h7FFF;
            end
        endcase
        if (mode == 0)
            return top;
        if (mode == 1)
            return 32'd0;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 20)
            return top;
        if (r < 35)
            return $urandom & top;
        return $urandom_range(hi, lo);
    endfunction

    task automatic apply_settings(input int mode);
        for (int i = 0; i < 8; i++)
            cfg_write(cfg_idx_t'(i), pick_setting(cfg_idx_t'(i), mode));
    endtask

    // encoder mostly tracks the scaled setpoint, with a little full-range noise
    task automatic send_random_word();
        int     spd;
        int     enc;
        int     noise;
        int     r;
        longint est;
        bit     link;
        r    = $urandom_range(0, 99);
        link = ($urandom_range(0, 99) < 92);
        if (r < 12) begin
            spd  = $urandom;
            enc  = $urandom;
            link = $urandom_range(0, 1);
        end
        else if (sb.closed_loop) begin
            spd = int'($urandom_range(0, 4000)) - 2000;
            est = spd;
            if (est > longint'(sb.speed_limit))
                est = longint'(sb.speed_limit);
            else if (est < -longint'(sb.speed_limit))
                est = -longint'(sb.speed_limit);
            est = (est * longint'(sb.ref_gain)) >>> REF_SHIFT;
            r = $urandom_range(0, 99);
            if (r < 40)
                noise = int'($urandom_range(0, 8)) - 4;
            else if (r < 80)
                noise = int'($urandom_range(0, 80)) - 40;
            else
                noise = int'($urandom_range(0, 2000)) - 1000;
            est = est + noise;
            if (est > 32767)
                est = 32767;
            else if (est < -32768)
                est = -32768;
            enc = int'(est);
        end
        else begin
            spd = int'($urandom_range(0, 300)) - 150;
            enc = $urandom;
        end
        send_word(spd, enc, link);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // registers at reset: zero gains keep the drive at zero
        send_word(32767, -32768, 1'b1);
        send_word(-32768, 32767, 1'b0);
        settle();

        cfg_write(REG_CLOSED_LOOP, 32'd1);
        cfg_write(REG_GAIN_P, 32'd256);
        cfg_write(REG_GAIN_I, 32'd256);
        cfg_write(REG_GAIN_D, 32'd128);
        cfg_write(REG_DEAD_BAND, 32'd10);
        cfg_write(REG_DUTY_LIMIT, 32'hFFFF);
        cfg_write(REG_REF_GAIN, 32'd65536);
        cfg_write(REG_SPEED_LIMIT, 32'h7FFF);
        send_word(5, 0, 1'b1);         // inside the deadband
        send_word(1000, 200, 1'b1);
        send_word(1000, 990, 1'b1);    // error right at the deadband edge
        send_word(32767, -32768, 1'b1);
        send_word(-32768, 32767, 1'b1);
        send_word(-32768, 32767, 1'b0);
        settle();

        // error terms pushed into saturation
        cfg_write(REG_REF_GAIN, 32'hFFFF_FFFF);
        cfg_write(REG_GAIN_P, 32'hFFFF);
        cfg_write(REG_GAIN_I, 32'hFFFF);
        cfg_write(REG_GAIN_D, 32'hFFFF);
        cfg_write(REG_DEAD_BAND, 32'hFFF);
        send_word(32767, -32768, 1'b1);
        send_word(-32768, 32767, 1'b1);
        send_word(32767, -32768, 1'b1);
        settle();

        // open loop percent drive, pid state left alone
        cfg_write(REG_CLOSED_LOOP, 32'd0);
        send_word(-32768, 0, 1'b1);
        send_word(-101, 0, 1'b1);
        send_word(-100, 0, 1'b1);
        send_word(-1, 0, 1'b1);
        send_word(0, 0, 1'b1);
        send_word(1, 0, 1'b1);
        send_word(33, 0, 1'b1);
        send_word(101, 0, 1'b0);
        send_word(32767, 0, 1'b1);
        settle();

        // smaller duty limit re-clamps a held accumulator
        cfg_write(REG_CLOSED_LOOP, 32'd1);
        cfg_write(REG_REF_GAIN, 32'd65536);
        cfg_write(REG_DUTY_LIMIT, 32'd100);
        send_word(0, 0, 1'b1);
        settle();

        cfg_write(REG_SPEED_LIMIT, 32'd0);
        cfg_write(REG_DUTY_LIMIT, 32'd0);
        cfg_write(REG_DEAD_BAND, 32'd0);
        send_word(32767, 5, 1'b1);
        send_word(-5, -32768, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            idle_on = (ph % 4 != 3);
            apply_settings(ph);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random_word();
        end
        settle();
        repeat (3 * DRAIN_CYCLES) @(posedge clk);

        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
        if (sb.errors == 0)
            $display("incremental_pid_motor_speed_control_tb: clean");
        else
            $display("incremental_pid_motor_speed_control_tb: errors");
        $finish;
    end

endmodule

// ===== incremental_pid_motor_speed_control.f =====
src/ipid_pkg.sv
src/ipid_sequencer.sv
src/incremental_pid_motor_speed_control.sv
tb/incremental_pid_motor_speed_control_tb.sv
